@@ sv/neighbor_cache_learn_lookup_assert.svh @@
// assertion macros for the neighbor cache learn and lookup block
`ifndef NEIGHBOR_CACHE_LEARN_LOOKUP_ASSERT_SVH
`define NEIGHBOR_CACHE_LEARN_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define NCL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("neighbor cache check failed");
// checked on every edge, reset included
`define NCL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("neighbor cache check failed");
`else
`define NCL_ASSERT(label, clk, rst, prop)
`define NCL_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ sv/ncl_pkg.sv @@
// shared types and constants of the neighbor cache
package ncl_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int IP_W   = 64;
  localparam int MAC_W  = 48;
  localparam int SLOT_W = 5;
  localparam int STAT_W = 3;

  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_HIT      = 3'd0;
  localparam status_t ST_MISS     = 3'd1;
  localparam status_t ST_UPDATED  = 3'd2;
  localparam status_t ST_INSERTED = 3'd3;
  localparam status_t ST_REPLACED = 3'd4;
  localparam status_t ST_IGNORED  = 3'd5;

  localparam logic ACT_LEARN  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [7:0]      MCAST_BYTE  = 8'hff;
  localparam logic [IP_W-1:0] LOOPBACK_HI = 64'd0;
  localparam logic [IP_W-1:0] LOOPBACK_LO = 64'd1;

  // write request from the sequencer to the entry store
  typedef struct packed {
    logic             en;
    logic             ip_en;
    logic [IDX_W-1:0] idx;
    logic [IP_W-1:0]  ip_hi;
    logic [IP_W-1:0]  ip_lo;
    logic [MAC_W-1:0] mac;
  } wr_req_t;

  // one entry as read back from the store
  typedef struct packed {
    logic             vld;
    logic [IP_W-1:0]  ip_hi;
    logic [IP_W-1:0]  ip_lo;
    logic [MAC_W-1:0] mac;
  } entry_t;

endpackage

@@ sv/neighbor_cache_learn_lookup.sv @@
// neighbor cache top level: request capture, entry walk sequencer, result register
// a learn or lookup walks all entries through one registered read port and one
// 128-bit compare unit; a new request is taken only once the result is loaded
// into the result register; an ignored learn skips the walk
// rst (synchronous) clears all valid marks, the sequencer and the result valid flag
`include "neighbor_cache_learn_lookup_assert.svh"
module neighbor_cache_learn_lookup (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         action,
  input  logic [ncl_pkg::IP_W-1:0]     ip_high,
  input  logic [ncl_pkg::IP_W-1:0]     ip_low,
  input  logic [ncl_pkg::MAC_W-1:0]    mac_addr,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output ncl_pkg::status_t             status,
  output logic [ncl_pkg::MAC_W-1:0]    mac_out,
  output logic [ncl_pkg::SLOT_W-1:0]   slot
);
  import ncl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  logic             act;
  logic [IP_W-1:0]  hi;
  logic [IP_W-1:0]  lo;
  logic [MAC_W-1:0] mac;
  logic             ign;

  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic [IDX_W-1:0] cmp_idx;

  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [MAC_W-1:0] hit_mac;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  wr_req_t          wr;

  logic req_take;
  logic finish;
  logic match;
  logic ign_in;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign finish    = (state == S_DONE) && !(rsp_valid && rsp_stall);

  assign ign_in = (action == ACT_LEARN) &&
                  ((ip_high[IP_W-1 -: 8] == MCAST_BYTE) ||
                   (ip_high == LOOPBACK_HI && ip_low == LOOPBACK_LO));

  // issue side of the walk
  assign rd_en   = (state == S_SCAN) && (cnt < CNT_W'(ENTRIES));
  assign rd_addr = cnt[IDX_W-1:0];

  // the shared compare unit
  assign match = pend && rd_data.vld && rd_data.ip_hi == hi && rd_data.ip_lo == lo;

  always_comb begin
    wr       = '0;
    wr.ip_hi = hi;
    wr.ip_lo = lo;
    wr.mac   = mac;
    if (finish && act == ACT_LEARN && !ign) begin
      wr.en = 1'b1;
      if (hit_found) begin
        wr.idx = hit_idx;
      end else if (free_found) begin
        wr.idx   = free_idx;
        wr.ip_en = 1'b1;
      end else begin
        wr.idx   = '0;
        wr.ip_en = 1'b1;
      end
    end
  end

  ncl_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (req_take) begin
      act <= action;
      hi  <= ip_high;
      lo  <= ip_low;
      mac <= mac_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ign        <= 1'b0;
      cnt        <= '0;
      pend       <= 1'b0;
      cmp_idx    <= '0;
      hit_found  <= 1'b0;
      hit_idx    <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take) begin
            ign        <= ign_in;
            cnt        <= '0;
            pend       <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= ign_in ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          pend    <= rd_en;
          cmp_idx <= rd_addr;
          if (rd_en) begin
            cnt <= cnt + CNT_W'(1);
          end
          if (match && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= cmp_idx;
            hit_mac   <= rd_data.mac;
          end
          if (pend && !rd_data.vld && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          // last entry is compared in the cycle with no new read
          if (!rd_en && pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      mac_out <= '0;
      slot    <= '0;
      if (act == ACT_LOOKUP) begin
        if (hit_found) begin
          status  <= ST_HIT;
          mac_out <= hit_mac;
          slot    <= SLOT_W'(hit_idx);
        end else begin
          status <= ST_MISS;
        end
      end else if (ign) begin
        status <= ST_IGNORED;
      end else if (hit_found) begin
        status <= ST_UPDATED;
        slot   <= SLOT_W'(hit_idx);
      end else if (free_found) begin
        status <= ST_INSERTED;
        slot   <= SLOT_W'(free_idx);
      end else begin
        status <= ST_REPLACED;
      end
    end
  end

  `NCL_ASSERT_ALWAYS(a_reset_drops_result, clk, rst |=> !rsp_valid)
  `NCL_ASSERT(a_result_from_done, clk, rst, $rose(rsp_valid) |-> $past(state == S_DONE))
  `NCL_ASSERT(a_mac_only_on_hit, clk, rst, rsp_valid && status != ST_HIT |-> mac_out == '0)
  `NCL_ASSERT(a_write_only_at_finish, clk, rst, wr.en |-> state == S_DONE && !ign)
  `NCL_ASSERT(a_walk_bounded, clk, rst, cnt <= CNT_W'(ENTRIES))

endmodule

@@ sv/ncl_store.sv @@
// entry store: address and mac memories with per-entry valid flops
`include "neighbor_cache_learn_lookup_assert.svh"
module ncl_store (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [ncl_pkg::IDX_W-1:0] rd_addr,
  input  ncl_pkg::wr_req_t      wr,
  output ncl_pkg::entry_t       rd_data
);
  import ncl_pkg::*;

  logic [IP_W-1:0]  ip_hi_mem [ENTRIES];
  logic [IP_W-1:0]  ip_lo_mem [ENTRIES];
  logic [MAC_W-1:0] mac_mem   [ENTRIES];
  logic [ENTRIES-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mac_mem[wr.idx] <= wr.mac;
      if (wr.ip_en) begin
        ip_hi_mem[wr.idx] <= wr.ip_hi;
        ip_lo_mem[wr.idx] <= wr.ip_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.ip_hi <= ip_hi_mem[rd_addr];
      rd_data.ip_lo <= ip_lo_mem[rd_addr];
      rd_data.mac   <= mac_mem[rd_addr];
      rd_data.vld   <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en && wr.ip_en) begin
      vld[wr.idx] <= 1'b1;
    end
  end

  `NCL_ASSERT(a_wr_sets_valid, clk, rst, wr.en && wr.ip_en |=> vld[$past(wr.idx)])
  `NCL_ASSERT_ALWAYS(a_reset_clears_valid, clk, rst |=> vld == '0)
  `NCL_ASSERT(a_mac_only_on_valid, clk, rst, wr.en && !wr.ip_en |-> vld[wr.idx])

endmodule

@@ tb/ncl_cache_checker.sv @@
`timescale 1ns / 100ps
// neighbor cache checker: watches both channels, predicts every result word and compares
module ncl_cache_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic                        action,
  input  logic [ncl_pkg::IP_W-1:0]    ip_high,
  input  logic [ncl_pkg::IP_W-1:0]    ip_low,
  input  logic [ncl_pkg::MAC_W-1:0]   mac_addr,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  ncl_pkg::status_t            status,
  input  logic [ncl_pkg::MAC_W-1:0]   mac_out,
  input  logic [ncl_pkg::SLOT_W-1:0]  slot,
  output int                          pending,
  output int                          failures,
  output int                          checked,
  output int                          hits,
  output int                          replaced,
  output logic [5:0]                  kinds_seen
);
  import ncl_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [MAC_W-1:0]  mac;
    logic [SLOT_W-1:0] slot;
  } cache_answer_t;

  // shadow copy of the cache
  logic             tbl_valid [ENTRIES];
  logic [IP_W-1:0]  tbl_hi    [ENTRIES];
  logic [IP_W-1:0]  tbl_lo    [ENTRIES];
  logic [MAC_W-1:0] tbl_mac   [ENTRIES];

  cache_answer_t answers_due [$];
  int            fail_total    = 0;
  int            checked_total = 0;
  int            hit_total     = 0;
  int            replace_total = 0;
  logic [5:0]    seen          = '0;

  function automatic int find_slot(input logic [IP_W-1:0] hi, input logic [IP_W-1:0] lo);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_hi[i] == hi && tbl_lo[i] == lo) return i;
    return -1;
  endfunction

  // applies one request to the shadow cache and returns the answer it must produce
  function automatic cache_answer_t cache_apply(input logic act, input logic [IP_W-1:0] hi,
                                                input logic [IP_W-1:0] lo,
                                                input logic [MAC_W-1:0] mac);
    cache_answer_t ans;
    int idx;
    ans = '0;
    idx = find_slot(hi, lo);
    if (act == ACT_LOOKUP) begin
      if (idx >= 0) begin
        ans.status = ST_HIT;
        ans.mac    = tbl_mac[idx];
        ans.slot   = SLOT_W'(idx);
      end else begin
        ans.status = ST_MISS;
      end
    end else if (hi[IP_W-1 -: 8] == MCAST_BYTE || (hi == LOOPBACK_HI && lo == LOOPBACK_LO)) begin
      ans.status = ST_IGNORED;
    end else if (idx >= 0) begin
      tbl_mac[idx] = mac;
      ans.status   = ST_UPDATED;
      ans.slot     = SLOT_W'(idx);
    end else begin
      // lowest free entry wins, entry zero is taken when none is free
      idx        = 0;
      ans.status = ST_REPLACED;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (!tbl_valid[i]) begin
          idx        = i;
          ans.status = ST_INSERTED;
        end
      end
      ans.slot       = SLOT_W'(idx);
      tbl_valid[idx] = 1'b1;
      tbl_hi[idx]    = hi;
      tbl_lo[idx]    = lo;
      tbl_mac[idx]   = mac;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    cache_answer_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      answers_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (answers_due.size() == 0) begin
          $error("result word with no request outstanding: status %0d slot %0d", status, slot);
          fail_total++;
        end else begin
          want = answers_due.pop_front();
          checked_total++;
          if (want.status == ST_HIT) hit_total++;
          if (want.status == ST_REPLACED) replace_total++;
          seen[want.status] = 1'b1;
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status);
            fail_total++;
          end
          if (mac_out !== want.mac) begin
            $error("mac_out mismatch: expected %h, got %h", want.mac, mac_out);
            fail_total++;
          end
          if (slot !== want.slot) begin
            $error("slot mismatch: expected %0d, got %0d", want.slot, slot);
            fail_total++;
          end
        end
      end
      if (req_valid && !req_stall)
        answers_due.push_back(cache_apply(action, ip_high, ip_low, mac_addr));
    end
    pending    <= answers_due.size();
    failures   <= fail_total;
    checked    <= checked_total;
    hits       <= hit_total;
    replaced   <= replace_total;
    kinds_seen <= seen;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// neighbor cache testbench top: clock, reset, request stimulus, result stalls and verdict
module tb_top;
  import ncl_pkg::*;

  localparam int POOL_SIZE    = 44;
  localparam int RANDOM_WORDS = 1880;
  localparam int DRAIN_EVERY  = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 40;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_COMB, RX_HOLD} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic              action;
  logic [IP_W-1:0]   ip_high;
  logic [IP_W-1:0]   ip_low;
  logic [MAC_W-1:0]  mac_addr;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  status_t           status;
  logic [MAC_W-1:0]  mac_out;
  logic [SLOT_W-1:0] slot;

  int         pending;
  int         failures;
  int         checked;
  int         hits;
  int         replaced;
  logic [5:0] kinds_seen;

  int       words_sent  = 0;
  int       burst_left  = 0;
  int       idle_cycles = 0;
  int       rx_left     = 0;
  rx_mode_t rx_mode     = RX_FREE;

  // addresses that come back again and again, so the table fills and overflows
  logic [IP_W-1:0] pool_hi [POOL_SIZE];
  logic [IP_W-1:0] pool_lo [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  neighbor_cache_learn_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .action    (action),
    .ip_high   (ip_high),
    .ip_low    (ip_low),
    .mac_addr  (mac_addr),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .mac_out   (mac_out),
    .slot      (slot)
  );

  ncl_cache_checker cache_chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .ip_high    (ip_high),
    .ip_low     (ip_low),
    .mac_addr   (mac_addr),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .mac_out    (mac_out),
    .slot       (slot),
    .pending    (pending),
    .failures   (failures),
    .checked    (checked),
    .hits       (hits),
    .replaced   (replaced),
    .kinds_seen (kinds_seen)
  );

  // result side stall pattern: free running, coin flips, short comb, long holds
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rx_left   <= 0;
      rx_mode   <= RX_FREE;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 400);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FREE: rsp_stall <= 1'b0;
        RX_COIN: rsp_stall <= ($urandom_range(0, 1) == 1);
        RX_COMB: rsp_stall <= ((rx_left % 7) < 3);
        default: rsp_stall <= ((rx_left % 53) < 45);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("neighbor_cache_learn_lookup verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // holds the word until taken, then either keeps the burst going or idles a while
  task automatic send_word(input logic act, input logic [IP_W-1:0] hi,
                           input logic [IP_W-1:0] lo, input logic [MAC_W-1:0] mac);
    int gap;
    req_valid <= 1'b1;
    action    <= act;
    ip_high   <= hi;
    ip_low    <= lo;
    mac_addr  <= mac;
    do @(posedge clk); while (req_stall);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 45);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
    end
  endtask

  // stop sending until every outstanding result word has come back
  task automatic drain();
    if (req_valid) req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [IP_W-1:0]  hi;
    logic [IP_W-1:0]  lo;
    logic [MAC_W-1:0] mac;
    int               pick;
    int               k;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    action    <= ACT_LEARN;
    ip_high   <= '0;
    ip_low    <= '0;
    mac_addr  <= '0;

    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_hi[i] = rand64();
      pool_hi[i][IP_W-1 -: 8] = 8'($urandom_range(0, 254));
      pool_lo[i] = rand64();
      // near neighbors: same upper half with one low bit flipped, or the reverse
      if (i % 2 == 1) begin
        pool_hi[i] = pool_hi[i-1];
        pool_lo[i] = pool_lo[i-1] ^ (64'd1 << $urandom_range(0, 63));
      end else if (i % 6 == 2) begin
        pool_hi[i] = pool_hi[i-2] ^ (64'd1 << $urandom_range(0, 55));
        pool_lo[i] = pool_lo[i-2];
      end
      if (i == 0) pool_hi[i] = '0;
      if (pool_hi[i] == LOOPBACK_HI && pool_lo[i] == LOOPBACK_LO) pool_lo[i] = 64'd2;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, ignored learns, field extremes, update and near misses
    send_word(ACT_LOOKUP, 64'd0, 64'd0, 48'd0);
    send_word(ACT_LEARN,  LOOPBACK_HI, LOOPBACK_LO, 48'hffff_ffff_ffff);
    send_word(ACT_LOOKUP, LOOPBACK_HI, LOOPBACK_LO, 48'd0);
    send_word(ACT_LEARN,  64'hff00_0000_0000_0000, 64'd0, 48'h0000_0000_0001);
    send_word(ACT_LEARN,  64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 48'hffff_ffff_ffff);
    send_word(ACT_LEARN,  64'd0, 64'd0, 48'd0);
    send_word(ACT_LEARN,  64'hfeff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 48'hffff_ffff_ffff);
    send_word(ACT_LEARN,  64'd0, 64'd2, 48'h1234_5678_9abc);
    send_word(ACT_LOOKUP, 64'd0, 64'd0, 48'hffff_ffff_ffff);
    send_word(ACT_LOOKUP, 64'hfeff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 48'd0);
    send_word(ACT_LEARN,  64'd0, 64'd0, 48'hffff_ffff_ffff);
    send_word(ACT_LOOKUP, 64'd0, 64'd0, 48'd0);
    send_word(ACT_LOOKUP, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 48'd0);
    send_word(ACT_LOOKUP, 64'd0, 64'd3, 48'd0);
    send_word(ACT_LEARN,  64'd1, 64'd1, 48'h8000_0000_0000);
    send_word(ACT_LOOKUP, LOOPBACK_HI, LOOPBACK_LO, 48'd0);
    send_word(ACT_LEARN,  64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 48'h8000_0000_0001);
    send_word(ACT_LOOKUP, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 48'd0);
    send_word(ACT_LEARN,  64'hff00_0000_0000_0000, 64'd1, 48'h5555_5555_5555);
    send_word(ACT_LOOKUP, 64'd0, 64'd2, 48'haaaa_aaaa_aaaa);
    send_word(ACT_LOOKUP, 64'd1, 64'd1, 48'd0);
    drain();

    // random: mostly traffic on the address pool, the rest fresh, multicast and loopback
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) drain();
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, POOL_SIZE - 1);
      mac  = 48'(rand64());
      hi   = pool_hi[k];
      lo   = pool_lo[k];
      if (pick < 35) begin
        send_word(ACT_LEARN, hi, lo, mac);
      end else if (pick < 70) begin
        send_word(ACT_LOOKUP, hi, lo, mac);
      end else if (pick < 78) begin
        send_word(ACT_LEARN, rand64(), rand64(), mac);
      end else if (pick < 84) begin
        send_word(ACT_LOOKUP, rand64(), rand64(), mac);
      end else if (pick < 90) begin
        hi = rand64();
        hi[IP_W-1 -: 8] = MCAST_BYTE;
        send_word(ACT_LEARN, hi, (pick < 87) ? lo : rand64(), mac);
      end else if (pick < 93) begin
        send_word(ACT_LEARN, LOOPBACK_HI, LOOPBACK_LO, mac);
      end else if (pick < 96) begin
        hi[IP_W-1 -: 8] = MCAST_BYTE;
        if (pick == 95) send_word(ACT_LOOKUP, LOOPBACK_HI, LOOPBACK_LO, mac);
        else send_word(ACT_LOOKUP, hi, lo, mac);
      end else begin
        // right upper half, wrong lower half
        send_word(pick[0] ? ACT_LOOKUP : ACT_LEARN, hi, rand64(), mac);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d request words and %0d checked results, %0d lookup hits, %0d full-table overwrites",
             words_sent, checked, hits, replaced);
    $display("result kinds seen, hit last: %b", kinds_seen);
    if (failures == 0) begin
      $display("neighbor_cache_learn_lookup verification clean");
    end else begin
      $display("neighbor_cache_learn_lookup verification failed");
    end
    $finish;
  end

endmodule

@@ neighbor_cache_learn_lookup.f @@
+incdir+sv
sv/ncl_pkg.sv
sv/ncl_store.sv
sv/neighbor_cache_learn_lookup.sv
tb/ncl_cache_checker.sv
tb/tb_top.sv
